>>> rtl/hec_pkg.sv
// Shared constants, configuration struct and position helpers for the
// Hamming encoder and syndrome checker. No dependencies.
package hec_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int CW_BITS       = 63;
  localparam int SYN_BITS      = 6;
  localparam int CFG_W         = 6;
  localparam int PC_W          = 3;
  localparam int GROUP_SIZE    = 16;
  localparam int GROUPS        = 4;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  typedef struct packed {
    logic [MAX_DATA_BITS-1:0] data_mask;
    logic [CW_BITS-1:0]       rx_mask;
    logic [PC_W-1:0]          parity_count;
  } cfg_t;

  typedef logic [SYN_BITS-1:0] part_t [GROUPS];

  // One-based codeword position of data bit k.
  function automatic logic [SYN_BITS-1:0] data_pos(input int k);
    int cnt;
    logic [SYN_BITS-1:0] res;
    cnt = 0;
    res = '0;
    for (int p = 1; p <= CW_BITS; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == k) res = SYN_BITS'(p);
        cnt++;
      end
    end
    return res;
  endfunction

  // Smallest r with 2^r >= m + r + 1.
  function automatic logic [PC_W-1:0] parity_bits_for(input logic [CFG_W-1:0] m);
    logic [PC_W-1:0] r;
    logic            found;
    r = PC_W'(6);
    found = 1'b0;
    for (int i = 1; i <= SYN_BITS; i++) begin
      if (!found && (7'(1 << i) >= 7'(m) + 7'(i) + 7'd1)) begin
        r = PC_W'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/hamming_encode_and_check_top.sv
// Top level of the even-parity Hamming encoder and syndrome checker.
// Depends on hec_pkg, hec_cfg, hec_front and hec_merge.
//
// One request is taken on every cycle that start is high; busy is always low.
// Each result appears for one cycle, marked by done, in request order, once
// the request has passed the three register stages (mask, partial syndromes,
// output). The receiver cannot stall, so results must be taken as they
// appear. The data width register is written through cfg_valid/cfg_ready
// (always ready) and must change only while no request is in flight.
module hamming_encode_and_check_top import hec_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     action,
  input  logic [MAX_DATA_BITS-1:0] data_word,
  input  logic [CW_BITS-1:0]       received_word,
  output logic                     done,
  output logic [CW_BITS-1:0]       codeword,
  output logic [SYN_BITS-1:0]      syndrome,
  output logic                     error_detected,
  output logic [PC_W-1:0]          parity_count
);

  cfg_t               cfg;
  logic               s2_valid;
  logic               s2_action;
  logic [CW_BITS-1:0] s2_word;
  part_t              s2_part;
  logic [PC_W-1:0]    s2_r;

  assign busy = 1'b0;

  hec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start && !busy),
    .cfg           (cfg),
    .action        (action),
    .data_word     (data_word),
    .received_word (received_word),
    .s2_valid      (s2_valid),
    .s2_action     (s2_action),
    .s2_word       (s2_word),
    .s2_part       (s2_part),
    .s2_r          (s2_r)
  );

  hec_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .s2_valid       (s2_valid),
    .s2_action      (s2_action),
    .s2_word        (s2_word),
    .s2_part        (s2_part),
    .s2_r           (s2_r),
    .done           (done),
    .codeword       (codeword),
    .syndrome       (syndrome),
    .error_detected (error_detected),
    .parity_count   (parity_count)
  );

endmodule

>>> rtl/hec_cfg.sv
// Data width register and the masks and parity count derived from it.
// Depends on hec_pkg.
module hec_cfg import hec_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [CFG_W-1:0] data_bits;
  logic [CFG_W-1:0] m;
  logic [CFG_W-1:0] n;
  logic [PC_W-1:0]  r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits <= CFG_W'(26);
    end else if (cfg_valid && cfg_ready) begin
      data_bits <= cfg_data;
    end
  end

  always_comb begin
    if (data_bits == '0) m = CFG_W'(1);
    else if (data_bits > CFG_W'(MAX_DATA_BITS)) m = CFG_W'(MAX_DATA_BITS);
    else m = data_bits;
    r = parity_bits_for(m);
    n = m + CFG_W'(r);
    for (int i = 0; i < MAX_DATA_BITS; i++) begin
      cfg.data_mask[i] = (7'(i) < 7'(m));
    end
    for (int i = 0; i < CW_BITS; i++) begin
      cfg.rx_mask[i] = (7'(i) < 7'(n));
    end
    cfg.parity_count = r;
  end

endmodule

>>> rtl/hec_front.sv
// Stages one and two: mask the request, scatter data into codeword
// positions and fold positions into per-group partial syndromes. Depends on hec_pkg.
module hec_front import hec_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  cfg_t                     cfg,
  input  logic                     action,
  input  logic [MAX_DATA_BITS-1:0] data_word,
  input  logic [CW_BITS-1:0]       received_word,
  output logic                     s2_valid,
  output logic                     s2_action,
  output logic [CW_BITS-1:0]       s2_word,
  output part_t                    s2_part,
  output logic [PC_W-1:0]          s2_r
);

  logic                     s1_valid;
  logic                     s1_action;
  logic [MAX_DATA_BITS-1:0] s1_data;
  logic [CW_BITS-1:0]       s1_rx;
  logic [PC_W-1:0]          s1_r;
  logic [CW_BITS-1:0]       word_next;
  part_t                    part_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_action <= action;
    s1_data   <= data_word & cfg.data_mask;
    s1_rx     <= received_word & cfg.rx_mask;
    s1_r      <= cfg.parity_count;
    s2_action <= s1_action;
    s2_word   <= word_next;
    s2_part   <= part_next;
    s2_r      <= s1_r;
  end

  always_comb begin
    if (s1_action == ACT_CHECK) begin
      word_next = s1_rx;
    end else begin
      word_next = '0;
      for (int k = 0; k < MAX_DATA_BITS; k++) begin
        word_next[data_pos(k) - SYN_BITS'(1)] = s1_data[k];
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if ((g * GROUP_SIZE + j >= 1) && (g * GROUP_SIZE + j <= CW_BITS)) begin
          if (word_next[g * GROUP_SIZE + j - 1]) begin
            part_next[g] = part_next[g] ^ SYN_BITS'(g * GROUP_SIZE + j);
          end
        end
      end
    end
  end

endmodule

>>> rtl/hec_merge.sv
// Stage three: combine partial syndromes, insert parity or report the
// check result into the output registers. Depends on hec_pkg.
module hec_merge import hec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s2_valid,
  input  logic               s2_action,
  input  logic [CW_BITS-1:0] s2_word,
  input  part_t              s2_part,
  input  logic [PC_W-1:0]    s2_r,
  output logic               done,
  output logic [CW_BITS-1:0] codeword,
  output logic [SYN_BITS-1:0] syndrome,
  output logic               error_detected,
  output logic [PC_W-1:0]    parity_count
);

  logic [SYN_BITS-1:0] syn;
  logic [CW_BITS-1:0]  cw_next;

  always_comb begin
    syn = '0;
    for (int g = 0; g < GROUPS; g++) begin
      syn = syn ^ s2_part[g];
    end
    cw_next = s2_word;
    for (int i = 0; i < SYN_BITS; i++) begin
      cw_next[(1 << i) - 1] = syn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    parity_count <= s2_r;
    if (s2_action == ACT_CHECK) begin
      codeword       <= '0;
      syndrome       <= syn;
      error_detected <= (syn != '0);
    end else begin
      codeword       <= cw_next;
      syndrome       <= '0;
      error_detected <= 1'b0;
    end
  end

  a_err_matches_syn: assert property (@(posedge clk) disable iff (rst)
    done |-> (error_detected == (syndrome != '0)))
    else $error("error flag disagrees with syndrome");

  a_encode_no_syn: assert property (@(posedge clk) disable iff (rst)
    (done && codeword != '0) |-> (syndrome == '0))
    else $error("encode result carries a syndrome");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    s2_valid |=> done)
    else $error("request dropped in last stage");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (parity_count >= PC_W'(2) && parity_count <= PC_W'(6)))
    else $error("parity count out of range");

endmodule

>>> bench/tb_hamming_encode_and_check_top.sv
// Testbench for hamming_encode_and_check_top: directed and random encode/check requests
// over many data widths, each result checked against a built-in predictor.
// Depends on hec_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_hamming_encode_and_check_top;
  import hec_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [CW_BITS-1:0]  cw;
    logic [SYN_BITS-1:0] syn;
    logic                err;
    logic [PC_W-1:0]     pc;
  } hec_result_t;

  class hamming_scoreboard;
    logic [CFG_W-1:0] data_bits;
    hec_result_t      expected_q[$];
    int               errors;

    function new();
      data_bits = CFG_W'(26);
      errors = 0;
    endfunction

    function int width_in_use();
      int m;
      m = int'(data_bits);
      if (m < 1) m = 1;
      if (m > MAX_DATA_BITS) m = MAX_DATA_BITS;
      return m;
    endfunction

    function int parity_for(int m);
      int r;
      r = 1;
      while (r < 7 && (1 << r) < m + r + 1) r++;
      return r;
    endfunction

    function int code_length();
      return width_in_use() + parity_for(width_in_use());
    endfunction

    function hec_result_t predict(logic act, logic [MAX_DATA_BITS-1:0] dw,
                                  logic [CW_BITS-1:0] rx);
      hec_result_t res;
      int m, r, n, k;
      logic [SYN_BITS-1:0] acc;
      res = '0;
      m = width_in_use();
      r = parity_for(m);
      n = m + r;
      acc = '0;
      k = 0;
      if (act == ACT_ENCODE) begin
        for (int p = 1; p <= n && p <= CW_BITS; p++) begin
          if ((p & (p - 1)) != 0) begin
            if (k < m && dw[k]) begin
              res.cw[p-1] = 1'b1;
              acc ^= SYN_BITS'(p);
            end
            k++;
          end
        end
        for (int i = 0; i < r && i < SYN_BITS; i++)
          if (acc[i]) res.cw[(1 << i) - 1] = 1'b1;
      end else begin
        for (int p = 1; p <= n && p <= CW_BITS; p++)
          if (rx[p-1]) acc ^= SYN_BITS'(p);
        res.syn = acc;
        res.err = (acc != '0);
      end
      res.pc = PC_W'(r);
      return res;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task note_request(logic act, logic [MAX_DATA_BITS-1:0] dw, logic [CW_BITS-1:0] rx);
      expected_q.push_back(predict(act, dw, rx));
    endtask

    task check_result(logic [CW_BITS-1:0] cw, logic [SYN_BITS-1:0] syn, logic err,
                      logic [PC_W-1:0] pc);
      hec_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, codeword %h", cw));
      end else begin
        want = expected_q.pop_front();
        if (cw !== want.cw)
          report($sformatf("codeword %h, want %h", cw, want.cw));
        if (syn !== want.syn)
          report($sformatf("syndrome %0d, want %0d", syn, want.syn));
        if (err !== want.err)
          report($sformatf("error_detected %b, want %b", err, want.err));
        if (pc !== want.pc)
          report($sformatf("parity_count %0d, want %0d", pc, want.pc));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     action = ACT_ENCODE;
  logic [MAX_DATA_BITS-1:0] data_word = '0;
  logic [CW_BITS-1:0]       received_word = '0;
  logic                     done;
  logic [CW_BITS-1:0]       codeword;
  logic [SYN_BITS-1:0]      syndrome;
  logic                     error_detected;
  logic [PC_W-1:0]          parity_count;

  hamming_scoreboard sb = new();
  int                quiet_cycles = 0;

  hamming_encode_and_check_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_request(action, data_word, received_word);
    if (!rst && done) sb.check_result(codeword, syndrome, error_detected, parity_count);
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic issue_request(logic act, logic [MAX_DATA_BITS-1:0] dw,
                               logic [CW_BITS-1:0] rx);
    start <= 1'b1;
    action <= act;
    data_word <= dw;
    received_word <= rx;
    do @(posedge clk); while (busy);
  endtask

  // Hold start low for a random pause while the fields carry noise.
  task automatic pause_requests();
    start <= 1'b0;
    action <= 1'($urandom);
    data_word <= MAX_DATA_BITS'(rand64());
    received_word <= CW_BITS'(rand64());
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic write_width(logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.data_bits = v;
  endtask

  // Single-bit error at one-based position pos.
  function automatic logic [CW_BITS-1:0] one_hot_pos(int pos);
    return CW_BITS'(1) << (pos - 1);
  endfunction

  task automatic directed_edges();
    int n;
    n = sb.code_length();
    issue_request(ACT_ENCODE, '1, '0);
    issue_request(ACT_CHECK, '0, '1);
    issue_request(ACT_CHECK, '0, one_hot_pos(n));
  endtask

  task automatic random_request();
    logic                     act;
    logic [MAX_DATA_BITS-1:0] dw;
    logic [CW_BITS-1:0]       rx;
    hec_result_t              clean;
    int                       n, kind;
    act = 1'($urandom);
    dw = MAX_DATA_BITS'(rand64());
    n = sb.code_length();
    kind = $urandom_range(9);
    if (kind == 0) dw = '0;
    if (kind == 1) dw = '1;
    if (kind < 4) begin
      rx = CW_BITS'(rand64());
    end else begin
      // Start from a clean codeword, then corrupt it.
      clean = sb.predict(ACT_ENCODE, dw, '0);
      rx = clean.cw;
      if (kind >= 6) rx[$urandom_range(n - 1)] ^= 1'b1;
      if (kind == 9) rx[$urandom_range(n - 1)] ^= 1'b1;
      if (kind == 5 && n < CW_BITS) rx[$urandom_range(CW_BITS - 1, n)] ^= 1'b1;
    end
    issue_request(act, dw, rx);
  endtask

  initial begin
    logic [CFG_W-1:0] widths[10];
    int               idle_pct;
    hec_result_t      clean;
    widths = '{CFG_W'(1), CFG_W'(57), CFG_W'(4), CFG_W'(58), CFG_W'(11),
               CFG_W'($urandom), CFG_W'($urandom), CFG_W'(2), CFG_W'($urandom),
               CFG_W'(26)};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset width: zeros, ones, unused data bits, bits beyond the codeword.
    issue_request(ACT_ENCODE, '0, '0);
    issue_request(ACT_ENCODE, '1, '0);
    issue_request(ACT_ENCODE, ~MAX_DATA_BITS'((64'd1 << sb.width_in_use()) - 1), '0);
    issue_request(ACT_CHECK, '0, '0);
    issue_request(ACT_CHECK, '0, ~CW_BITS'((64'd1 << sb.code_length()) - 1));
    clean = sb.predict(ACT_ENCODE, '1, '0);
    issue_request(ACT_CHECK, '0, clean.cw);
    directed_edges();

    // Width zero acts as one; widths above the maximum clamp to it.
    write_width(CFG_W'(0));
    directed_edges();
    write_width(CFG_W'(63));
    directed_edges();
    write_width(CFG_W'(57));
    directed_edges();

    // Phases: no idling, sender idle 85%, no idling, sender idle 32%.
    for (int b = 0; b < 10; b++) begin
      write_width(widths[b]);
      idle_pct = (b % 4 == 1) ? 85 : (b % 4 == 3) ? 32 : 0;
      for (int i = 0; i < 125; i++) begin
        if ((i / 16) % 4 != 3 && $urandom_range(99) < idle_pct) pause_requests();
        random_request();
      end
    end

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
